>>> src/depth_pixel_backprojection_unit_assert.svh
// ----------------------------------------------------------------------------
// depth pixel backprojection assertion macros
// shared property forms for the checker of the backprojection unit
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_BACKPROJECTION_UNIT_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle, off while reset is high
`define DPB_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must never be seen outside reset
`define DPB_ASSERT_NEVER(name, clk, rst, bad, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(bad)) else $error(msg);

`endif

>>> src/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg
// types, widths, register codes and reset values of the backprojection unit
// ----------------------------------------------------------------------------
package dpb_pkg;

  localparam int PIXEL_COORD_BITS_DEF = 12;

  localparam int DEPTH_BITS  = 16;
  localparam int COLOUR_BITS = 8;
  localparam int CENTRE_BITS = 16;
  localparam int RECIP_BITS  = 24;
  localparam int COORD_BITS  = 32;
  localparam int COEF_BITS   = 18;
  localparam int TRANS_BITS  = 21;
  localparam int MODE_BITS   = 2;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 63;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TRANSFORM_MODE      = 3'd0,
    REG_PRINCIPAL_POINT     = 3'd1,
    REG_INVERSE_FOCAL       = 3'd2,
    REG_INVERSE_DEPTH_SCALE = 3'd3,
    REG_ROTATION_ROW_A      = 3'd4,
    REG_ROTATION_ROW_B      = 3'd5,
    REG_ROTATION_ROW_C      = 3'd6,
    REG_TRANSLATION         = 3'd7
  } cfg_reg_t;

  localparam logic [MODE_BITS-1:0] MODE_RIGID = 2'd2;

  localparam logic [MODE_BITS-1:0] TRANSFORM_MODE_RST      = 2'd0;
  localparam logic [31:0]          PRINCIPAL_POINT_RST     = 32'd247010291;
  localparam logic [47:0]          INVERSE_FOCAL_RST       = 48'd462111665021;
  localparam logic [23:0]          INVERSE_DEPTH_SCALE_RST = 24'd16777;
  localparam logic [53:0]          ROTATION_ROW_A_RST      = 54'd65536;
  localparam logic [53:0]          ROTATION_ROW_B_RST      = 54'd17179869184;
  localparam logic [53:0]          ROTATION_ROW_C_RST      = 54'd4503599627370496;
  localparam logic [62:0]          TRANSLATION_RST         = 63'd0;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // valid bit and colour that ride along with each item
  typedef struct packed {
    logic                   valid;
    logic [COLOUR_BITS-1:0] red;
    logic [COLOUR_BITS-1:0] green;
    logic [COLOUR_BITS-1:0] blue;
  } tag_t;

endpackage

>>> src/dpb_project.sv
// ----------------------------------------------------------------------------
// dpb_project
// four-stage pinhole back-projection of one pixel to a camera-frame point
// ----------------------------------------------------------------------------
module dpb_project #(
  parameter int PIXEL_COORD_BITS = dpb_pkg::PIXEL_COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dpb_pkg::tag_t                     in_tag,
  input  logic [PIXEL_COORD_BITS-1:0]       pix_u,
  input  logic [PIXEL_COORD_BITS-1:0]       pix_v,
  input  logic [dpb_pkg::DEPTH_BITS-1:0]    depth,
  input  logic [dpb_pkg::CENTRE_BITS-1:0]   centre_x,
  input  logic [dpb_pkg::CENTRE_BITS-1:0]   centre_y,
  input  logic [dpb_pkg::RECIP_BITS-1:0]    inv_fx,
  input  logic [dpb_pkg::RECIP_BITS-1:0]    inv_fy,
  input  logic [dpb_pkg::RECIP_BITS-1:0]    inv_scale,
  output dpb_pkg::tag_t                     out_tag,
  output dpb_pkg::coord_t                   p_x,
  output dpb_pkg::coord_t                   p_y,
  output dpb_pkg::coord_t                   p_z
);

  localparam int CW  = dpb_pkg::COORD_BITS;
  localparam int RB  = dpb_pkg::RECIP_BITS;
  localparam int SUB = PIXEL_COORD_BITS + 4;
  // offset magnitude width
  localparam int MW  = (SUB > dpb_pkg::CENTRE_BITS) ? SUB : dpb_pkg::CENTRE_BITS;
  localparam int XW  = MW + RB;
  localparam int TW  = MW + 12;
  localparam int PW  = TW + CW;
  localparam int RW  = PW - 16;
  localparam int ZPW = dpb_pkg::DEPTH_BITS + RB;

  // sign-magnitude to signed, saturated to the coordinate range
  function automatic dpb_pkg::coord_t sat_sm(input logic [RW-1:0] mag, input logic neg);
    logic [CW-1:0] low;
    low = mag[CW-1:0];
    if (|mag[RW-1:CW-1]) begin
      sat_sm = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      sat_sm = neg ? -$signed(low) : $signed(low);
    end
  endfunction

  // stage 1: offsets from the principal point and raw depth product
  logic [MW:0]      du_x, du_y;
  logic [MW-1:0]    s1_mag_x, s1_mag_y;
  logic             s1_neg_x, s1_neg_y;
  logic [ZPW-1:0]   s1_zprod;
  dpb_pkg::tag_t    s1_tag;

  assign du_x = (MW+1)'({pix_u, 4'b0000}) - (MW+1)'(centre_x);
  assign du_y = (MW+1)'({pix_v, 4'b0000}) - (MW+1)'(centre_y);

  always_ff @(posedge clk) begin
    s1_neg_x <= du_x[MW];
    s1_neg_y <= du_y[MW];
    s1_mag_x <= du_x[MW] ? MW'(-du_x) : du_x[MW-1:0];
    s1_mag_y <= du_y[MW] ? MW'(-du_y) : du_y[MW-1:0];
    s1_zprod <= ZPW'(depth) * ZPW'(inv_scale);
    s1_tag   <= rst ? '0 : in_tag;
  end

  // stage 2: scale offsets by the inverse focal lengths, round depth
  logic [XW-1:0]  tx_prod, ty_prod, tx_rnd, ty_rnd;
  logic [ZPW-1:0] z_rnd;
  logic [TW-1:0]  s2_t_x, s2_t_y;
  logic [CW-1:0]  s2_z;
  logic           s2_neg_x, s2_neg_y;
  dpb_pkg::tag_t  s2_tag;

  assign tx_prod = XW'(s1_mag_x) * XW'(inv_fx);
  assign ty_prod = XW'(s1_mag_y) * XW'(inv_fy);
  assign tx_rnd  = tx_prod + XW'(2048);
  assign ty_rnd  = ty_prod + XW'(2048);
  assign z_rnd   = s1_zprod + ZPW'(128);

  always_ff @(posedge clk) begin
    s2_t_x   <= tx_rnd[XW-1:12];
    s2_t_y   <= ty_rnd[XW-1:12];
    s2_z     <= z_rnd[ZPW-1:8];
    s2_neg_x <= s1_neg_x;
    s2_neg_y <= s1_neg_y;
    s2_tag   <= rst ? '0 : s1_tag;
  end

  // stage 3: multiply by depth
  logic [PW-1:0] s3_prod_x, s3_prod_y;
  logic [CW-1:0] s3_z;
  logic          s3_neg_x, s3_neg_y;
  dpb_pkg::tag_t s3_tag;

  always_ff @(posedge clk) begin
    s3_prod_x <= PW'(s2_t_x) * PW'(s2_z);
    s3_prod_y <= PW'(s2_t_y) * PW'(s2_z);
    s3_z      <= s2_z;
    s3_neg_x  <= s2_neg_x;
    s3_neg_y  <= s2_neg_y;
    s3_tag    <= rst ? '0 : s2_tag;
  end

  // stage 4: round, apply sign, saturate
  logic [PW-1:0] rx, ry;

  assign rx = s3_prod_x + PW'(32768);
  assign ry = s3_prod_y + PW'(32768);

  always_ff @(posedge clk) begin
    p_x     <= sat_sm(rx[PW-1:16], s3_neg_x);
    p_y     <= sat_sm(ry[PW-1:16], s3_neg_y);
    p_z     <= s3_z[CW-1] ? {1'b0, {(CW-1){1'b1}}} : $signed(s3_z);
    out_tag <= rst ? '0 : s3_tag;
  end

endmodule

>>> src/dpb_transform.sv
// ----------------------------------------------------------------------------
// dpb_transform
// three-stage rigid transform of a camera-frame point, with frame bypass
// ----------------------------------------------------------------------------
module dpb_transform (
  input  logic                  clk,
  input  logic                  rst,
  input  dpb_pkg::tag_t         in_tag,
  input  dpb_pkg::coord_t       p_x,
  input  dpb_pkg::coord_t       p_y,
  input  dpb_pkg::coord_t       p_z,
  input  logic                  rigid,
  input  logic [53:0]           row_a,
  input  logic [53:0]           row_b,
  input  logic [53:0]           row_c,
  input  logic [62:0]           translation,
  output dpb_pkg::tag_t         out_tag,
  output dpb_pkg::coord_t       q_x,
  output dpb_pkg::coord_t       q_y,
  output dpb_pkg::coord_t       q_z
);

  localparam int CW    = dpb_pkg::COORD_BITS;
  localparam int KB    = dpb_pkg::COEF_BITS;
  localparam int TB    = dpb_pkg::TRANS_BITS;
  localparam int MPW   = KB + CW;
  localparam int ACC_W = 54;
  localparam int SHW   = ACC_W - 16;

  logic [53:0]     rows [3];
  dpb_pkg::coord_t p_in [3];

  assign rows[0] = row_a;
  assign rows[1] = row_b;
  assign rows[2] = row_c;
  assign p_in[0] = p_x;
  assign p_in[1] = p_y;
  assign p_in[2] = p_z;

  // stage 5: nine coefficient products
  logic signed [MPW-1:0] s5_prod [3][3];
  dpb_pkg::coord_t       s5_cam [3];
  dpb_pkg::tag_t         s5_tag;

  // stage 6: row sums with translation and rounding bias
  logic signed [ACC_W-1:0] acc_next [3];
  logic signed [ACC_W-1:0] s6_acc [3];
  dpb_pkg::coord_t         s6_cam [3];
  dpb_pkg::tag_t           s6_tag;

  // stage 7: floor shift and saturate
  logic signed [SHW-1:0] sh [3];
  dpb_pkg::coord_t       q_next [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar k = 0; k < 3; k++) begin : g_col
      always_ff @(posedge clk) begin
        s5_prod[r][k] <= MPW'($signed(rows[r][KB*k +: KB])) * MPW'(p_in[k]);
      end
    end

    always_comb begin
      logic signed [TB-1:0] t;
      t = $signed(translation[TB*r +: TB]);
      acc_next[r] = ACC_W'(s5_prod[r][0]) + ACC_W'(s5_prod[r][1])
                  + ACC_W'(s5_prod[r][2])
                  + $signed({{(ACC_W-TB-22){t[TB-1]}}, t, 22'b0})
                  + ACC_W'(32768);
    end

    assign sh[r] = SHW'(s6_acc[r] >>> 16);

    always_comb begin
      if (sh[r][SHW-1:CW-1] == '0 || sh[r][SHW-1:CW-1] == '1) begin
        q_next[r] = sh[r][CW-1:0];
      end else begin
        q_next[r] = sh[r][SHW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
    end

    always_ff @(posedge clk) begin
      s5_cam[r] <= p_in[r];
      s6_acc[r] <= acc_next[r];
      s6_cam[r] <= s5_cam[r];
    end
  end

  always_ff @(posedge clk) begin
    s5_tag  <= rst ? '0 : in_tag;
    s6_tag  <= rst ? '0 : s5_tag;
    q_x     <= rigid ? q_next[0] : s6_cam[0];
    q_y     <= rigid ? q_next[1] : s6_cam[1];
    q_z     <= rigid ? q_next[2] : s6_cam[2];
    out_tag <= rst ? '0 : s6_tag;
  end

endmodule

>>> src/depth_pixel_backprojection_unit.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_unit
// RGB-D pixel to coloured 3-D point, pinhole model with optional rigid transform
// ----------------------------------------------------------------------------
// One pixel is taken on every clock with start high and busy low; busy is high only
// while rst is held. A pixel with zero depth produces nothing. Any other pixel
// produces exactly one point unless rst is raised in flight, shown with done for
// a single cycle once it has passed through an input register, four stages of
// back-projection (offset, inverse-focal multiply, depth multiply, round and
// saturate) and three stages of transform (coefficient products, row sums, shift
// and saturate). Points come out in pixel order and cannot be held off, so the
// receiver must take each one as it appears. Configuration registers are written
// with cfg_we and should only change while no pixel is in flight.
module depth_pixel_backprojection_unit #(
  parameter int PIXEL_COORD_BITS = dpb_pkg::PIXEL_COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [PIXEL_COORD_BITS-1:0]          pixel_column,
  input  logic [PIXEL_COORD_BITS-1:0]          pixel_row,
  input  logic [dpb_pkg::COLOUR_BITS-1:0]      colour_first,
  input  logic [dpb_pkg::COLOUR_BITS-1:0]      colour_second,
  input  logic [dpb_pkg::COLOUR_BITS-1:0]      colour_third,
  input  logic [dpb_pkg::DEPTH_BITS-1:0]       depth_raw,
  output dpb_pkg::coord_t                      point_x,
  output dpb_pkg::coord_t                      point_y,
  output dpb_pkg::coord_t                      point_z,
  output logic [dpb_pkg::COLOUR_BITS-1:0]      red,
  output logic [dpb_pkg::COLOUR_BITS-1:0]      green,
  output logic [dpb_pkg::COLOUR_BITS-1:0]      blue,
  output logic                                 done,
  input  logic                                 cfg_we,
  input  logic [dpb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [dpb_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  // configuration registers
  logic [dpb_pkg::MODE_BITS-1:0] transform_mode;
  logic [31:0]                   principal_point;
  logic [47:0]                   inverse_focal;
  logic [23:0]                   inverse_depth_scale;
  logic [53:0]                   rotation_row_a;
  logic [53:0]                   rotation_row_b;
  logic [53:0]                   rotation_row_c;
  logic [62:0]                   translation;

  always_ff @(posedge clk) begin
    if (rst) begin
      transform_mode      <= dpb_pkg::TRANSFORM_MODE_RST;
      principal_point     <= dpb_pkg::PRINCIPAL_POINT_RST;
      inverse_focal       <= dpb_pkg::INVERSE_FOCAL_RST;
      inverse_depth_scale <= dpb_pkg::INVERSE_DEPTH_SCALE_RST;
      rotation_row_a      <= dpb_pkg::ROTATION_ROW_A_RST;
      rotation_row_b      <= dpb_pkg::ROTATION_ROW_B_RST;
      rotation_row_c      <= dpb_pkg::ROTATION_ROW_C_RST;
      translation         <= dpb_pkg::TRANSLATION_RST;
    end else if (cfg_we) begin
      unique case (dpb_pkg::cfg_reg_t'(cfg_index))
        dpb_pkg::REG_TRANSFORM_MODE:      transform_mode      <= cfg_data[1:0];
        dpb_pkg::REG_PRINCIPAL_POINT:     principal_point     <= cfg_data[31:0];
        dpb_pkg::REG_INVERSE_FOCAL:       inverse_focal       <= cfg_data[47:0];
        dpb_pkg::REG_INVERSE_DEPTH_SCALE: inverse_depth_scale <= cfg_data[23:0];
        dpb_pkg::REG_ROTATION_ROW_A:      rotation_row_a      <= cfg_data[53:0];
        dpb_pkg::REG_ROTATION_ROW_B:      rotation_row_b      <= cfg_data[53:0];
        dpb_pkg::REG_ROTATION_ROW_C:      rotation_row_c      <= cfg_data[53:0];
        dpb_pkg::REG_TRANSLATION:         translation         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign busy = rst;

  // input register; zero-depth pixels enter as empty slots, busy keeps it empty in reset
  dpb_pkg::tag_t                  in_tag;
  logic [PIXEL_COORD_BITS-1:0]    u_q, v_q;
  logic [dpb_pkg::DEPTH_BITS-1:0] depth_q;

  always_ff @(posedge clk) begin
    in_tag  <= '{valid: start && !busy && (depth_raw != '0),
                 red: colour_first, green: colour_second, blue: colour_third};
    u_q     <= pixel_column;
    v_q     <= pixel_row;
    depth_q <= depth_raw;
  end

  dpb_pkg::tag_t   cam_tag, out_tag;
  dpb_pkg::coord_t cam_x, cam_y, cam_z;

  dpb_project #(
    .PIXEL_COORD_BITS(PIXEL_COORD_BITS)
  ) u_project (
    .clk       (clk),
    .rst       (rst),
    .in_tag    (in_tag),
    .pix_u     (u_q),
    .pix_v     (v_q),
    .depth     (depth_q),
    .centre_x  (principal_point[15:0]),
    .centre_y  (principal_point[31:16]),
    .inv_fx    (inverse_focal[23:0]),
    .inv_fy    (inverse_focal[47:24]),
    .inv_scale (inverse_depth_scale),
    .out_tag   (cam_tag),
    .p_x       (cam_x),
    .p_y       (cam_y),
    .p_z       (cam_z)
  );

  dpb_transform u_transform (
    .clk         (clk),
    .rst         (rst),
    .in_tag      (cam_tag),
    .p_x         (cam_x),
    .p_y         (cam_y),
    .p_z         (cam_z),
    .rigid       (transform_mode == dpb_pkg::MODE_RIGID),
    .row_a       (rotation_row_a),
    .row_b       (rotation_row_b),
    .row_c       (rotation_row_c),
    .translation (translation),
    .out_tag     (out_tag),
    .q_x         (point_x),
    .q_y         (point_y),
    .q_z         (point_z)
  );

  assign done  = out_tag.valid;
  assign red   = out_tag.red;
  assign green = out_tag.green;
  assign blue  = out_tag.blue;

endmodule

>>> src/dpb_checker.sv
// ----------------------------------------------------------------------------
// dpb_checker
// port-level checks of busy, latency, item count and colour pass-through
// ----------------------------------------------------------------------------
`include "depth_pixel_backprojection_unit_assert.svh"

module dpb_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic [dpb_pkg::COLOUR_BITS-1:0]    colour_first,
  input logic [dpb_pkg::COLOUR_BITS-1:0]    colour_second,
  input logic [dpb_pkg::COLOUR_BITS-1:0]    colour_third,
  input logic [dpb_pkg::DEPTH_BITS-1:0]     depth_raw,
  input logic [dpb_pkg::COLOUR_BITS-1:0]    red,
  input logic [dpb_pkg::COLOUR_BITS-1:0]    green,
  input logic [dpb_pkg::COLOUR_BITS-1:0]    blue,
  input logic                               done
);

  localparam int LATENCY = 8;

  logic              take_item;
  logic [LATENCY-1:0] rst_hist;

  assign take_item = start && !busy && (depth_raw != '0);

  // reset seen inside the latency window kills the item in flight
  always_ff @(posedge clk) begin
    rst_hist <= {rst_hist[LATENCY-2:0], rst};
  end

  `DPB_ASSERT_NEVER(a_busy_only_in_reset, clk, rst, busy, "busy outside reset")

  `DPB_ASSERT_IMP(a_no_phantom, clk, rst, done, $past(take_item, LATENCY), "point without pixel")

  `DPB_ASSERT_IMP(a_no_loss, clk, rst, $past(take_item, LATENCY) && !(|rst_hist), done, "pixel lost")

  `DPB_ASSERT_IMP(a_colour, clk, rst, done, red == $past(colour_first, LATENCY) && green == $past(colour_second, LATENCY) && blue == $past(colour_third, LATENCY), "colour mismatch")

endmodule

bind depth_pixel_backprojection_unit dpb_checker u_dpb_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .colour_first  (colour_first),
  .colour_second (colour_second),
  .colour_third  (colour_third),
  .depth_raw     (depth_raw),
  .red           (red),
  .green         (green),
  .blue          (blue),
  .done          (done)
);
